/* rtl/rpn_pkg.sv */
// rpn_pkg: shared types and codes for the reverse Polish stack calculator
// request/response payloads, opcode and status codes, controller command and status
// no dependencies
package rpn_pkg;

	localparam logic [2:0] OP_PUSH = 3'd0;
	localparam logic [2:0] OP_ADD  = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_MUL  = 3'd3;
	localparam logic [2:0] OP_DIV  = 3'd4;
	localparam logic [2:0] OP_SHOW = 3'd5;

	localparam logic [2:0] STS_OK    = 3'd0;
	localparam logic [2:0] STS_FEW   = 3'd1;
	localparam logic [2:0] STS_DIVZ  = 3'd2;
	localparam logic [2:0] STS_EMPTY = 3'd3;
	localparam logic [2:0] STS_FULL  = 3'd4;

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [31:0] push_value;
	} rpn_req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] top_value;
		logic [4:0]         depth;
	} rpn_rsp_t;

	typedef struct packed {
		logic       capture;
		logic       push;
		logic       read;
		logic       commit;
		logic       mul_start;
		logic       div_start;
		logic       div_step;
		logic       load_out;
		logic [2:0] status;
	} ctl_cmd_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic       empty;
		logic       few;
		logic       full;
		logic       divisor_zero;
		logic       div_done;
	} ctl_sts_t;

endpackage

/* rtl/rpn_stack_calculator.sv */
// rpn_stack_calculator: reverse Polish stack calculator, signed fixed point, one response
// per request. Push, show and errors go straight from decode to the response register;
// multiply adds one 32x32 multiplier stage; divide runs a restoring divider, one quotient
// bit per cycle over 32+FRAC_BITS bits. One request at a time; the next is taken as soon
// as the response is registered, even while it waits to be taken.
// Reset clears the stack count and control state; stack RAM contents are left as they are.
module rpn_stack_calculator
	import rpn_pkg::*;
#(
	parameter int STACK_DEPTH = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  rpn_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output rpn_rsp_t rsp
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	rpn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rpn_dp #(
		.STACK_DEPTH (STACK_DEPTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

/* rtl/rpn_ram.sv */
// rpn_ram: generic single write port, single read port RAM
// registered read data, no reset on contents; no dependencies
module rpn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/rpn_dp.sv */
// rpn_dp: datapath - stack RAM, cached top entry, count, add/sub, multiplier,
// restoring divider and response register; uses rpn_pkg and rpn_ram
module rpn_dp
	import rpn_pkg::*;
#(
	parameter int STACK_DEPTH = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  rpn_req_t req,
	input  ctl_cmd_t cmd,
	output ctl_sts_t sts,
	output rpn_rsp_t rsp
);

	localparam int AW   = $clog2(STACK_DEPTH);
	localparam int CW0  = $clog2(STACK_DEPTH + 1);
	localparam int CNTW = (CW0 > 5) ? CW0 : 5;
	localparam int NB   = 32 + FRAC_BITS;
	localparam int DCW  = $clog2(NB + 1);

	function automatic logic [31:0] pack_sat(input logic neg, input logic [63:0] mag);
		logic [31:0] r;
		if (neg) begin
			if (mag > 64'h0000_0000_8000_0000) r = 32'h8000_0000;
			else r = 32'd0 - mag[31:0];
		end else begin
			if (mag > 64'h0000_0000_7FFF_FFFF) r = 32'h7FFF_FFFF;
			else r = mag[31:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] sat33(input logic [32:0] s);
		logic [31:0] r;
		if (s[32] != s[31]) r = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		else r = s[31:0];
		return r;
	endfunction

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	logic [2:0]      op_q;
	logic [31:0]     val_q;
	logic [31:0]     top_q;
	logic [CNTW-1:0] count_q;
	logic [63:0]     prod_q;
	logic            neg_q;
	logic [NB-1:0]   dq_q;
	logic [31:0]     dv_q;
	logic [31:0]     rem_q;
	logic [DCW-1:0]  dcnt_q;
	rpn_rsp_t        rsp_q;

	logic [31:0]     a;
	logic [CNTW-1:0] below;
	logic [32:0]     sum;
	logic [32:0]     diff;
	logic [31:0]     res;
	logic [63:0]     prod;
	logic [32:0]     rem_sh;
	logic            ge;
	logic            we;
	logic [AW-1:0]   waddr;
	logic [31:0]     wdata;

	assign below = count_q - CNTW'(2);

	rpn_ram #(
		.WIDTH (32),
		.DEPTH (STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.read),
		.raddr (below[AW-1:0]),
		.rdata (a)
	);

	assign sum  = {a[31], a} + {top_q[31], top_q};
	assign diff = {a[31], a} - {top_q[31], top_q};
	assign prod = 64'(mag32(a)) * 64'(mag32(top_q));

	always_comb begin
		case (op_q)
			OP_ADD:  res = sat33(sum);
			OP_SUB:  res = sat33(diff);
			OP_MUL:  res = pack_sat(neg_q, prod_q >> FRAC_BITS);
			default: res = pack_sat(neg_q, 64'(dq_q));
		endcase
	end

	assign we    = cmd.push | cmd.commit;
	assign waddr = cmd.push ? count_q[AW-1:0] : below[AW-1:0];
	assign wdata = cmd.push ? val_q : res;

	assign rem_sh = {rem_q, dq_q[NB-1]};
	assign ge     = rem_sh >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.push) begin
			count_q <= count_q + CNTW'(1);
		end else if (cmd.commit) begin
			count_q <= count_q - CNTW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= req.opcode;
			val_q <= req.push_value;
		end
		if (cmd.push) begin
			top_q <= val_q;
		end else if (cmd.commit) begin
			top_q <= res;
		end
		if (cmd.mul_start) begin
			prod_q <= prod;
		end
		if (cmd.mul_start || cmd.div_start) begin
			neg_q <= a[31] ^ top_q[31];
		end
		if (cmd.div_start) begin
			dq_q   <= NB'(mag32(a)) << FRAC_BITS;
			dv_q   <= mag32(top_q);
			rem_q  <= '0;
			dcnt_q <= DCW'(NB);
		end else if (cmd.div_step) begin
			rem_q  <= ge ? 32'(rem_sh - {1'b0, dv_q}) : rem_sh[31:0];
			dq_q   <= {dq_q[NB-2:0], ge};
			dcnt_q <= dcnt_q - DCW'(1);
		end
		if (cmd.load_out) begin
			rsp_q.status    <= cmd.status;
			rsp_q.top_value <= (count_q != '0) ? top_q : 32'd0;
			rsp_q.depth     <= count_q[4:0];
		end
	end

	assign sts.opcode       = op_q;
	assign sts.empty        = count_q == '0;
	assign sts.few          = count_q < CNTW'(2);
	assign sts.full         = count_q >= CNTW'(STACK_DEPTH);
	assign sts.divisor_zero = top_q == 32'd0;
	assign sts.div_done     = dcnt_q == '0;

	assign rsp = rsp_q;

endmodule

/* rtl/rpn_ctrl.sv */
// rpn_ctrl: controller state machine, request/response handshake and status code
// drives rpn_dp through ctl_cmd_t; uses rpn_pkg
module rpn_ctrl
	import rpn_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_FETCH  = 6'b000100,
		S_MUL    = 6'b001000,
		S_DIV    = 6'b010000,
		S_OUT    = 6'b100000
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] st_q, st_d;
	logic       rsp_valid_q;

	always_comb begin
		state_d     = state_q;
		st_d        = st_q;
		cmd         = '0;
		cmd.status  = st_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				st_d    = STS_OK;
				state_d = S_OUT;
				case (sts.opcode)
					OP_PUSH: begin
						if (sts.full) st_d = STS_FULL;
						else cmd.push = 1'b1;
					end
					OP_ADD, OP_SUB, OP_MUL: begin
						if (sts.few) begin
							st_d = STS_FEW;
						end else begin
							cmd.read = 1'b1;
							state_d  = S_FETCH;
						end
					end
					OP_DIV: begin
						if (sts.few) begin
							st_d = STS_FEW;
						end else if (sts.divisor_zero) begin
							st_d = STS_DIVZ;
						end else begin
							cmd.read = 1'b1;
							state_d  = S_FETCH;
						end
					end
					OP_SHOW: begin
						if (sts.empty) st_d = STS_EMPTY;
					end
					default: begin
						st_d = STS_OK;
					end
				endcase
			end
			S_FETCH: begin
				case (sts.opcode)
					OP_MUL: begin
						cmd.mul_start = 1'b1;
						state_d       = S_MUL;
					end
					OP_DIV: begin
						cmd.div_start = 1'b1;
						state_d       = S_DIV;
					end
					default: begin
						cmd.commit = 1'b1;
						state_d    = S_OUT;
					end
				endcase
			end
			S_MUL: begin
				cmd.commit = 1'b1;
				state_d    = S_OUT;
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.commit = 1'b1;
					state_d    = S_OUT;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_OUT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			st_q        <= STS_OK;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;

endmodule

/* rtl/rpn_checker.sv */
// rpn_checker: port-level assertions for rpn_stack_calculator
// bound to the top level below; uses rpn_pkg
module rpn_checker
	import rpn_pkg::*;
#(
	parameter int STACK_DEPTH = 16
) (
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_stall,
	input logic     rsp_valid,
	input logic     rsp_stall,
	input rpn_rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed or dropped");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second transaction taken while one is in progress");

	a_empty_top_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.depth == 5'd0 && STACK_DEPTH < 32 |-> rsp.top_value == 32'sd0)
		else $error("empty stack reports non-zero top");

	a_full_depth: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STS_FULL |-> rsp.depth == 5'(STACK_DEPTH))
		else $error("full status without a full stack");

	a_empty_depth: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STS_EMPTY |-> rsp.depth == 5'd0 && rsp.top_value == 32'sd0)
		else $error("empty status with entries on the stack");

endmodule

bind rpn_stack_calculator rpn_checker #(
	.STACK_DEPTH (STACK_DEPTH)
) u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

/* tb/sv/tb_rpn_stack_calculator.sv */
// tb_rpn_stack_calculator: self-checking testbench for the reverse Polish stack calculator
// a scoreboard class predicts every response from a model of the stack, a plain task drives
// requests, an initial block stalls responses; depends on rpn_pkg and rpn_stack_calculator
module tb_rpn_stack_calculator
	import rpn_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;
	localparam int FRAC = 16;
	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 800;

	localparam logic [2:0] OP_RSVD_A = 3'd6;
	localparam logic [2:0] OP_RSVD_B = 3'd7;

	localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;
	localparam logic [31:0] Q_ONE = 32'h0001_0000;
	localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;

	class rpn_scoreboard;
		bit [31:0] stack_mem[DEPTH];
		int unsigned count;
		rpn_rsp_t expected_q[$];
		int errors;

		function new();
			count = 0;
			errors = 0;
		endfunction

		function bit [31:0] pack_sat(bit neg, bit [63:0] mag);
			if (neg) begin
				if (mag > 64'h8000_0000)
					mag = 64'h8000_0000;
				return 32'd0 - mag[31:0];
			end
			if (mag > 64'h7FFF_FFFF)
				mag = 64'h7FFF_FFFF;
			return mag[31:0];
		endfunction

		function bit [63:0] mag_of(longint v);
			return (v < 0) ? 64'(-v) : 64'(v);
		endfunction

		function bit [31:0] sat_wide(longint s);
			return (s < 0) ? pack_sat(1'b1, 64'(-s)) : pack_sat(1'b0, 64'(s));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_request(rpn_req_t item);
			rpn_rsp_t exp_rsp;
			bit [31:0] first;
			bit [31:0] second;
			bit [31:0] res;
			longint x;
			longint y;
			bit neg;
			bit [2:0] sts;

			sts = STS_OK;
			case (item.opcode)
				OP_PUSH: begin
					if (count >= DEPTH)
						sts = STS_FULL;
					else begin
						stack_mem[count] = item.push_value;
						count++;
					end
				end
				OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
					if (count < 2)
						sts = STS_FEW;
					else begin
						first = stack_mem[count - 2];
						second = stack_mem[count - 1];
						x = longint'($signed(first));
						y = longint'($signed(second));
						neg = (x < 0) != (y < 0);
						res = '0;
						case (item.opcode)
							OP_ADD: res = sat_wide(x + y);
							OP_SUB: res = sat_wide(x - y);
							OP_MUL: res = pack_sat(neg, (mag_of(x) * mag_of(y)) >> FRAC);
							default: begin
								if (second == 0)
									sts = STS_DIVZ;
								else
									res = pack_sat(neg, (mag_of(x) << FRAC) / mag_of(y));
							end
						endcase
						if (sts == STS_OK) begin
							count--;
							stack_mem[count - 1] = res;
						end
					end
				end
				OP_SHOW: begin
					if (count == 0)
						sts = STS_EMPTY;
				end
				default: ;
			endcase
			exp_rsp.status = sts;
			exp_rsp.top_value = (count != 0) ? stack_mem[count - 1] : '0;
			exp_rsp.depth = count[4:0];
			expected_q.push_back(exp_rsp);
		endfunction

		function void check_response(rpn_rsp_t got);
			rpn_rsp_t exp_rsp;

			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected response: status %0d top %h depth %0d",
						got.status, got.top_value, got.depth);
				return;
			end
			exp_rsp = expected_q.pop_front();
			if (got.status !== exp_rsp.status || got.top_value !== exp_rsp.top_value ||
					got.depth !== exp_rsp.depth) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: expected status %0d top %h depth %0d,",
						" got status %0d top %h depth %0d"},
						exp_rsp.status, exp_rsp.top_value, exp_rsp.depth,
						got.status, got.top_value, got.depth);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	rpn_req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rpn_rsp_t rsp;

	rpn_scoreboard sb;
	bit src_idle;
	bit sink_idle;
	bit hold_req;
	int idle_cycles;

	rpn_stack_calculator #(
		.STACK_DEPTH(DEPTH),
		.FRAC_BITS(FRAC)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] gen_value();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 7))
					0: return Q_MAX;
					1: return Q_MIN;
					2: return 32'd0;
					3: return 32'd1;
					4: return 32'hFFFF_FFFF;
					5: return Q_ONE;
					6: return Q_NEG_ONE;
					default: return 32'h0000_8000;
				endcase
			end
			1: return 32'd0;
			2, 3: return $urandom;
			4, 5: return $urandom_range(0, 32'h7FFFF) - 32'h40000;
			default: return $urandom_range(0, 32'h3FF_FFFF) - 32'h200_0000;
		endcase
	endfunction

	task automatic send_op(logic [2:0] op, logic [31:0] value);
		rpn_req_t item;
		int gap;

		item.opcode = op;
		item.push_value = value;
		gap = src_idle ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		sb.note_request(item);
	endtask

	// response side: random stalls per transaction plus one long hold-off
	initial begin
		int n;

		rsp_stall = 1'b0;
		forever begin
			if (hold_req) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			n = sink_idle ? $urandom_range(0, 8) : 0;
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall)
			sb.check_response(rsp);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("rpn_stack_calculator regression: fail");
				$finish;
			end
		end
	end

	initial begin
		int sent;
		int fill_run;
		int r;
		logic [2:0] op;

		sb = new();
		idle_cycles = 0;
		hold_req = 1'b0;
		src_idle = 1'b1;
		sink_idle = 1'b1;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty and short stack, saturation, divide by zero, reserved opcodes
		send_op(OP_SHOW, $urandom);
		send_op(OP_ADD, 32'd0);
		send_op(OP_PUSH, Q_MAX);
		send_op(OP_DIV, 32'd0);
		send_op(OP_PUSH, Q_MAX);
		send_op(OP_ADD, 32'd0);
		send_op(OP_PUSH, Q_MIN);
		send_op(OP_SUB, 32'd0);
		send_op(OP_PUSH, Q_MIN);
		send_op(OP_MUL, 32'd0);
		send_op(OP_PUSH, 32'd0);
		send_op(OP_DIV, 32'hFFFF_FFFF);
		send_op(OP_SUB, 32'd0);
		send_op(OP_PUSH, Q_NEG_ONE);
		send_op(OP_DIV, 32'd0);
		send_op(OP_PUSH, 32'h0001_8000);
		send_op(OP_MUL, 32'd0);
		send_op(OP_PUSH, 32'hFFFF_FFFF);
		send_op(OP_MUL, 32'd0);
		send_op(OP_PUSH, 32'h0003_0000);
		send_op(OP_DIV, 32'd0);
		send_op(OP_RSVD_A, 32'hFFFF_FFFF);
		send_op(OP_RSVD_B, 32'h5A5A_A5A5);
		send_op(OP_SHOW, 32'd0);
		send_op(OP_SUB, 32'd0);

		// random: mostly well-formed work on the stack, bursts to full, some noise
		sent = 0;
		fill_run = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent % 100 == 0) begin
				src_idle = $urandom_range(0, 3) != 0;
				sink_idle = $urandom_range(0, 3) != 0;
			end
			if (sent == 300) begin
				src_idle = 1'b0;
				hold_req = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (fill_run > 0) begin
				op = OP_PUSH;
				fill_run--;
			end else if (r < 3) begin
				op = OP_PUSH;
				fill_run = DEPTH + 1 - sb.count + $urandom_range(0, 2);
			end else if (r < 13) begin
				op = 3'($urandom_range(0, 7));
			end else if (sb.count < 2) begin
				op = ($urandom_range(0, 9) == 0) ? OP_SHOW : OP_PUSH;
			end else if (sb.count >= DEPTH - 2) begin
				op = 3'($urandom_range(OP_ADD, OP_DIV));
			end else begin
				r = $urandom_range(0, 9);
				if (r < 4)
					op = OP_PUSH;
				else if (r < 9)
					op = 3'($urandom_range(OP_ADD, OP_DIV));
				else
					op = OP_SHOW;
			end
			send_op(op, gen_value());
			if (op <= OP_SHOW)
				sent++;
		end
		req_valid <= 1'b0;
		src_idle = 1'b1;
		sink_idle = 1'b1;

		while (sb.pending() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("rpn_stack_calculator regression: pass");
		else
			$display("rpn_stack_calculator regression: fail");
		$finish;
	end

endmodule

/* files.f */
rtl/rpn_pkg.sv
rtl/rpn_ram.sv
rtl/rpn_dp.sv
rtl/rpn_ctrl.sv
rtl/rpn_stack_calculator.sv
rtl/rpn_checker.sv
tb/sv/tb_rpn_stack_calculator.sv
